/* rtl/core/dfel_pkg.sv */
// Types and constants shared by the fault event ring log core and its checker.
package dfel_pkg;

    localparam int unsigned PADDR_W = 3;

    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [8:0]  CAP_RESET  = 9'd256;
    localparam logic [15:0] CODE_LIMIT = 16'd64;
    localparam logic [9:0]  MILLIS_MAX = 10'd999;

    localparam logic [2:0] OP_RAISE   = 3'd0;
    localparam logic [2:0] OP_RESOLVE = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_STATS   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CODE  = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [2:0]         operation;
        logic [15:0]        fault_code;
        logic signed [31:0] detail_a;
        logic signed [31:0] detail_b;
        logic [31:0]        time_seconds;
        logic [15:0]        time_millis;
        logic [7:0]         read_index;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic               logged;
        logic [5:0]         read_code;
        logic signed [31:0] read_detail_a;
        logic signed [31:0] read_detail_b;
        logic [31:0]        read_seconds;
        logic [9:0]         read_millis;
        logic               read_resolved;
        logic [8:0]         count_out;
        logic [31:0]        total_out;
        logic [63:0]        fault_mask;
    } t_out;

    typedef struct packed {
        logic               resolved;
        logic [9:0]         millis;
        logic [31:0]        seconds;
        logic signed [31:0] detail_b;
        logic signed [31:0] detail_a;
        logic [5:0]         code;
    } t_entry;

endpackage

/* rtl/core/deduplicating_fault_event_ring_log_core.sv */
// Fault event ring log with a 64-bit active fault bitmap that drops repeated raises
// and resolves. One transaction is in work at a time: an accepted transaction passes
// through the execute step, which updates the pointers and bitmap and issues the
// single write or read of the entry memory, and then the done step, which moves the
// registered read data into the output register once that register is free. A new
// transaction is taken in the same cycle its predecessor lands in the output register.
// The output register lets the next transaction start while a result waits.
// The entry memory is not cleared after reset; the stored count gates every read.
module deduplicating_fault_event_ring_log_core #(
    parameter int unsigned SLOTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfel_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dfel_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dfel_pkg::t_out                o_out_data
);

    localparam int unsigned CAP_MAX = (SLOTS < 511) ? SLOTS : 511;
    localparam int unsigned CW      = $clog2(CAP_MAX + 1);
    localparam int unsigned SW      = $clog2(CAP_MAX);
    localparam int unsigned AW      = $clog2(SLOTS);
    localparam int unsigned XW      = (CW + 1 > 9) ? CW + 1 : 9;

    function automatic logic [CW-1:0] f_eff_cap(input logic [8:0] cap);
        if (cap == 9'd0) begin
            return CW'(1);
        end else if (32'(cap) > 32'(CAP_MAX)) begin
            return CW'(CAP_MAX);
        end else begin
            return CW'(cap);
        end
    endfunction

    dfel_pkg::t_state r_state, n_state;
    dfel_pkg::t_in    r_item;
    logic [8:0]       r_capacity, n_capacity;
    logic [SW-1:0]    r_next, n_next;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_total, n_total;
    logic [63:0]      r_mask, n_mask;
    logic [1:0]       r_status, n_status;
    logic             r_logged, n_logged;
    logic             r_rd_ok, n_rd_ok;
    logic             r_out_valid, n_out_valid;
    dfel_pkg::t_out   r_out, n_out;

    logic             cfg_wr, in_acc, out_free, load_out;
    logic [CW-1:0]    cap, cfg_cap;
    logic             is_append, code_ok, active, want, do_log, is_read, rd_ok;
    logic [5:0]       bit_sel;
    logic [SW-1:0]    slot, next_after;
    logic [CW-1:0]    slot_inc;
    logic [XW-1:0]    base, pos;
    logic [9:0]       millis_clamped;
    dfel_pkg::t_entry wr_entry, rd_entry;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == dfel_pkg::S_IDLE)
                          || ((r_state == dfel_pkg::S_DONE) && out_free));
    assign in_acc   = i_in_valid && !o_in_stall;
    assign load_out = (r_state == dfel_pkg::S_DONE) && out_free;

    always_comb begin
        prdata = '0;
        if (paddr[2] == dfel_pkg::REG_CAPACITY) begin
            prdata = 32'(r_capacity);
        end
    end

    always_comb begin
        cap       = f_eff_cap(r_capacity);
        cfg_cap   = f_eff_cap(pwdata[8:0]);
        is_append = (r_item.operation == dfel_pkg::OP_RAISE)
                    || (r_item.operation == dfel_pkg::OP_RESOLVE);
        is_read   = (r_item.operation == dfel_pkg::OP_READ);
        code_ok   = r_item.fault_code < dfel_pkg::CODE_LIMIT;
        bit_sel   = r_item.fault_code[5:0];
        active    = r_mask[bit_sel];
        want      = (r_item.operation == dfel_pkg::OP_RAISE);
        do_log    = is_append && code_ok && (active != want);

        slot       = (CW'(r_next) < cap) ? r_next : '0;
        slot_inc   = CW'(slot) + CW'(1);
        next_after = (slot_inc >= cap) ? '0 : SW'(slot_inc);

        millis_clamped = (r_item.time_millis > 16'(dfel_pkg::MILLIS_MAX))
                         ? dfel_pkg::MILLIS_MAX : r_item.time_millis[9:0];
        wr_entry.resolved = !want;
        wr_entry.millis   = millis_clamped;
        wr_entry.seconds  = r_item.time_seconds;
        wr_entry.detail_b = r_item.detail_b;
        wr_entry.detail_a = r_item.detail_a;
        wr_entry.code     = bit_sel;

        rd_ok = is_read && (XW'(r_item.read_index) < XW'(r_count));
        if (XW'(r_next) >= XW'(r_count)) begin
            base = XW'(r_next) - XW'(r_count);
        end else begin
            base = XW'(r_next) + XW'(cap) - XW'(r_count);
        end
        pos = base + XW'(r_item.read_index);
        if (pos >= XW'(cap)) begin
            pos = pos - XW'(cap);
        end
    end

    dfel_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  ((r_state == dfel_pkg::S_EXEC) && do_log),
        .i_wr_addr(AW'(slot)),
        .i_wr_data(wr_entry),
        .i_rd_en  ((r_state == dfel_pkg::S_EXEC) && rd_ok),
        .i_rd_addr(AW'(pos)),
        .o_rd_data(rd_entry)
    );

    always_comb begin
        n_state     = r_state;
        n_capacity  = r_capacity;
        n_next      = r_next;
        n_count     = r_count;
        n_total     = r_total;
        n_mask      = r_mask;
        n_status    = r_status;
        n_logged    = r_logged;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            dfel_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = dfel_pkg::S_EXEC;
                end
                if (cfg_wr && (paddr[2] == dfel_pkg::REG_CAPACITY)) begin
                    n_capacity = pwdata[8:0];
                    if (r_count > cfg_cap) begin
                        n_count = cfg_cap;
                    end
                    if (CW'(r_next) >= cfg_cap) begin
                        n_next = '0;
                    end
                end
            end
            dfel_pkg::S_EXEC: begin
                n_state  = dfel_pkg::S_DONE;
                n_logged = do_log;
                n_rd_ok  = rd_ok;
                if (is_append && !code_ok) begin
                    n_status = dfel_pkg::ST_BAD_CODE;
                end else if (is_read && !rd_ok) begin
                    n_status = dfel_pkg::ST_BAD_INDEX;
                end else begin
                    n_status = dfel_pkg::ST_OK;
                end
                if (do_log) begin
                    n_next  = next_after;
                    n_total = r_total + 32'd1;
                    if (r_count < cap) begin
                        n_count = r_count + CW'(1);
                    end
                    if (want) begin
                        n_mask = r_mask | (64'd1 << bit_sel);
                    end else begin
                        n_mask = r_mask & ~(64'd1 << bit_sel);
                    end
                end
                if (r_item.operation == dfel_pkg::OP_CLEAR) begin
                    n_next  = '0;
                    n_count = '0;
                    n_total = '0;
                    n_mask  = '0;
                end
            end
            dfel_pkg::S_DONE: begin
                if (load_out) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.logged        = r_logged;
                    n_out.read_code     = r_rd_ok ? rd_entry.code     : '0;
                    n_out.read_detail_a = r_rd_ok ? rd_entry.detail_a : '0;
                    n_out.read_detail_b = r_rd_ok ? rd_entry.detail_b : '0;
                    n_out.read_seconds  = r_rd_ok ? rd_entry.seconds  : '0;
                    n_out.read_millis   = r_rd_ok ? rd_entry.millis   : '0;
                    n_out.read_resolved = r_rd_ok ? rd_entry.resolved : 1'b0;
                    n_out.count_out     = 9'(r_count);
                    n_out.total_out     = r_total;
                    n_out.fault_mask    = r_mask;
                    n_state = in_acc ? dfel_pkg::S_EXEC : dfel_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dfel_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dfel_pkg::S_IDLE;
            r_capacity  <= dfel_pkg::CAP_RESET;
            r_next      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_capacity  <= n_capacity;
            r_next      <= n_next;
            r_count     <= n_count;
            r_total     <= n_total;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_status <= n_status;
        r_logged <= n_logged;
        r_rd_ok  <= n_rd_ok;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/dfel_store.sv */
// Entry memory of the ring: one write port, one read port with registered data.
module dfel_store #(
    parameter int unsigned SLOTS = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  dfel_pkg::t_entry         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output dfel_pkg::t_entry         o_rd_data
);

    dfel_pkg::t_entry r_mem [SLOTS];
    dfel_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/dfel_checker.sv */
// Port-level checker for the fault event ring log core and its bind.
module dfel_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input dfel_pkg::t_out               o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction dropped or changed while stalled");

    a_logged_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.logged |-> o_out_data.status == dfel_pkg::ST_OK)
        else $error("logged transaction reports an error status");

    a_err_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != dfel_pkg::ST_OK)
        |-> (o_out_data.read_seconds == 32'd0) && (o_out_data.read_millis == 10'd0)
            && (o_out_data.read_code == 6'd0))
        else $error("read fields not zero on error");

    a_millis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.read_millis <= dfel_pkg::MILLIS_MAX)
        else $error("read milliseconds above clamp");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken during execute step");

endmodule

bind deduplicating_fault_event_ring_log_core dfel_checker u_dfel_checker (.*);
